// ===== hw/rtl/fvs_pkg.sv =====
// ----------------------------------------------------------------------------
// fvs_pkg: shared types, constants and microprogram
// Types, slot map, operation codes and the microprogram for the
// flux vector splitting core.
// ----------------------------------------------------------------------------
`default_nettype none

package fvs_pkg;

    localparam int CfgW     = 18;
    localparam int SlotW    = 6;
    localparam int PcW      = 7;
    localparam int IdxW     = 4;
    localparam int NumFlux  = 5;

    localparam logic [CfgW-1:0] GAMMA_RESET = 18'd91750;

    // configuration register indexes
    localparam logic CFG_GAMMA_LEFT  = 1'b0;
    localparam logic CFG_GAMMA_RIGHT = 1'b1;

    // fixed-point constants, Q15.16
    localparam logic signed [31:0] Q_ZERO    = 32'sd0;
    localparam logic signed [31:0] Q_HALF    = 32'sd32768;
    localparam logic signed [31:0] Q_QUARTER = 32'sd16384;
    localparam logic signed [31:0] Q_ONE     = 32'sd65536;
    localparam logic signed [31:0] Q_TWO     = 32'sd131072;

    // scratch memory slots; the first fifteen are loaded at intake
    localparam logic [SlotW-1:0] SL_RHO  = 6'd0;
    localparam logic [SlotW-1:0] SL_U    = 6'd1;
    localparam logic [SlotW-1:0] SL_V    = 6'd2;
    localparam logic [SlotW-1:0] SL_W    = 6'd3;
    localparam logic [SlotW-1:0] SL_P    = 6'd4;
    localparam logic [SlotW-1:0] SL_NX   = 6'd5;
    localparam logic [SlotW-1:0] SL_NY   = 6'd6;
    localparam logic [SlotW-1:0] SL_NZ   = 6'd7;
    localparam logic [SlotW-1:0] SL_NT   = 6'd8;
    localparam logic [SlotW-1:0] SL_G    = 6'd9;
    localparam logic [SlotW-1:0] SL_ZERO = 6'd10;
    localparam logic [SlotW-1:0] SL_HALF = 6'd11;
    localparam logic [SlotW-1:0] SL_QTR  = 6'd12;
    localparam logic [SlotW-1:0] SL_ONE  = 6'd13;
    localparam logic [SlotW-1:0] SL_TWO  = 6'd14;
    localparam logic [SlotW-1:0] SL_DN   = 6'd15;
    localparam logic [SlotW-1:0] SL_C    = 6'd16;
    localparam logic [SlotW-1:0] SL_V2   = 6'd17;
    localparam logic [SlotW-1:0] SL_VN   = 6'd18;
    localparam logic [SlotW-1:0] SL_MACH = 6'd19;
    localparam logic [SlotW-1:0] SL_E    = 6'd20;
    localparam logic [SlotW-1:0] SL_T0   = 6'd21;
    localparam logic [SlotW-1:0] SL_T1   = 6'd22;
    localparam logic [SlotW-1:0] SL_FM   = 6'd24;
    localparam logic [SlotW-1:0] SL_FMD  = 6'd25;
    localparam logic [SlotW-1:0] SL_TWOC = 6'd26;
    localparam logic [SlotW-1:0] SL_VDN  = 6'd27;
    localparam logic [SlotW-1:0] SL_K    = 6'd28;
    localparam logic [SlotW-1:0] SL_H1   = 6'd29;
    localparam logic [SlotW-1:0] SL_H2   = 6'd30;
    localparam logic [SlotW-1:0] SL_H3   = 6'd31;
    localparam logic [SlotW-1:0] SL_H4   = 6'd32;
    localparam logic [SlotW-1:0] SL_EN   = 6'd33;

    localparam logic [IdxW-1:0] INTAKE_LAST = 4'd14;

    // flux component indexes for the finish operation
    localparam logic [SlotW-1:0] FX_MASS = 6'd0;
    localparam logic [SlotW-1:0] FX_MX   = 6'd1;
    localparam logic [SlotW-1:0] FX_MY   = 6'd2;
    localparam logic [SlotW-1:0] FX_MZ   = 6'd3;
    localparam logic [SlotW-1:0] FX_EN   = 6'd4;

    // program labels
    localparam logic [PcW-1:0] L_FULL = 7'd68;
    localparam logic [PcW-1:0] L_FIN  = 7'd84;
    localparam logic [PcW-1:0] L_NONE = 7'd90;

    typedef enum logic [3:0] {
        OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_ADDS, OP_NEGR, OP_SQ0, OP_SQA,
        OP_NORM, OP_SQRT, OP_BRNONE, OP_BRFULL, OP_JMP, OP_FIN, OP_END
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SlotW-1:0] dst;
        logic [SlotW-1:0] a;
        logic [SlotW-1:0] b;
        logic [PcW-1:0]   tgt;
    } t_instr;

    typedef struct packed {
        logic               side;
        logic [30:0]        density;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        pressure;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] grid_speed_term;
    } t_item;

    typedef struct packed {
        logic            capture;
        logic            intake;
        logic [IdxW-1:0] idx;
        logic            rd;
        logic            go;
        logic            load_out;
        t_instr          ins;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic take;
        logic side;
    } t_stat;

    function automatic t_instr mk(input t_op op, input logic [SlotW-1:0] d,
                                  input logic [SlotW-1:0] a,
                                  input logic [SlotW-1:0] b,
                                  input logic [PcW-1:0] t);
        t_instr r;
        r.op  = op;
        r.dst = d;
        r.a   = a;
        r.b   = b;
        r.tgt = t;
        return r;
    endfunction

    function automatic t_instr ucode(input logic [PcW-1:0] pc);
        t_instr r;
        case (pc)
            // face norm, sound speed, kinetic terms, Mach number, energy
            7'd0:  r = mk(OP_SQ0,  SL_T0,   SL_NX,   SL_NX,   7'd0);
            7'd1:  r = mk(OP_SQA,  SL_T0,   SL_NY,   SL_NY,   7'd0);
            7'd2:  r = mk(OP_SQA,  SL_T0,   SL_NZ,   SL_NZ,   7'd0);
            7'd3:  r = mk(OP_NORM, SL_DN,   SL_ZERO, SL_ZERO, 7'd0);
            7'd4:  r = mk(OP_MUL,  SL_T0,   SL_G,    SL_P,    7'd0);
            7'd5:  r = mk(OP_DIV,  SL_T0,   SL_T0,   SL_RHO,  7'd0);
            7'd6:  r = mk(OP_SQRT, SL_C,    SL_T0,   SL_ZERO, 7'd0);
            7'd7:  r = mk(OP_MUL,  SL_T0,   SL_U,    SL_U,    7'd0);
            7'd8:  r = mk(OP_MUL,  SL_T1,   SL_V,    SL_V,    7'd0);
            7'd9:  r = mk(OP_ADD,  SL_T0,   SL_T0,   SL_T1,   7'd0);
            7'd10: r = mk(OP_MUL,  SL_T1,   SL_W,    SL_W,    7'd0);
            7'd11: r = mk(OP_ADD,  SL_V2,   SL_T0,   SL_T1,   7'd0);
            7'd12: r = mk(OP_MUL,  SL_T0,   SL_U,    SL_NX,   7'd0);
            7'd13: r = mk(OP_MUL,  SL_T1,   SL_V,    SL_NY,   7'd0);
            7'd14: r = mk(OP_ADD,  SL_T0,   SL_T0,   SL_T1,   7'd0);
            7'd15: r = mk(OP_MUL,  SL_T1,   SL_W,    SL_NZ,   7'd0);
            7'd16: r = mk(OP_ADD,  SL_T0,   SL_T0,   SL_T1,   7'd0);
            7'd17: r = mk(OP_ADD,  SL_VN,   SL_T0,   SL_NT,   7'd0);
            7'd18: r = mk(OP_MUL,  SL_T0,   SL_C,    SL_DN,   7'd0);
            7'd19: r = mk(OP_DIV,  SL_MACH, SL_VN,   SL_T0,   7'd0);
            7'd20: r = mk(OP_MUL,  SL_T0,   SL_HALF, SL_V2,   7'd0);
            7'd21: r = mk(OP_SUB,  SL_T1,   SL_G,    SL_ONE,  7'd0);
            7'd22: r = mk(OP_MUL,  SL_T1,   SL_RHO,  SL_T1,   7'd0);
            7'd23: r = mk(OP_DIV,  SL_T1,   SL_P,    SL_T1,   7'd0);
            7'd24: r = mk(OP_ADD,  SL_E,    SL_T0,   SL_T1,   7'd0);
            7'd25: r = mk(OP_BRNONE, SL_T0, SL_MACH, SL_MACH, L_NONE);
            7'd26: r = mk(OP_BRFULL, SL_T0, SL_MACH, SL_MACH, L_FULL);
            // polynomial split
            7'd27: r = mk(OP_ADDS, SL_T0,   SL_MACH, SL_ONE,  7'd0);
            7'd28: r = mk(OP_MUL,  SL_T1,   SL_QTR,  SL_RHO,  7'd0);
            7'd29: r = mk(OP_MUL,  SL_T1,   SL_T1,   SL_C,    7'd0);
            7'd30: r = mk(OP_MUL,  SL_T1,   SL_T1,   SL_T0,   7'd0);
            7'd31: r = mk(OP_MUL,  SL_T1,   SL_T1,   SL_T0,   7'd0);
            7'd32: r = mk(OP_NEGR, SL_FM,   SL_T1,   SL_T1,   7'd0);
            7'd33: r = mk(OP_MUL,  SL_FMD,  SL_FM,   SL_DN,   7'd0);
            7'd34: r = mk(OP_MUL,  SL_TWOC, SL_TWO,  SL_C,    7'd0);
            7'd35: r = mk(OP_DIV,  SL_VDN,  SL_VN,   SL_DN,   7'd0);
            7'd36: r = mk(OP_SUB,  SL_T0,   SL_ZERO, SL_VDN,  7'd0);
            7'd37: r = mk(OP_ADDS, SL_K,    SL_T0,   SL_TWOC, 7'd0);
            7'd38: r = mk(OP_DIV,  SL_T0,   SL_NX,   SL_DN,   7'd0);
            7'd39: r = mk(OP_MUL,  SL_T0,   SL_T0,   SL_K,    7'd0);
            7'd40: r = mk(OP_DIV,  SL_T0,   SL_T0,   SL_G,    7'd0);
            7'd41: r = mk(OP_ADD,  SL_T0,   SL_T0,   SL_U,    7'd0);
            7'd42: r = mk(OP_MUL,  SL_H1,   SL_FMD,  SL_T0,   7'd0);
            7'd43: r = mk(OP_DIV,  SL_T0,   SL_NY,   SL_DN,   7'd0);
            7'd44: r = mk(OP_MUL,  SL_T0,   SL_T0,   SL_K,    7'd0);
            7'd45: r = mk(OP_DIV,  SL_T0,   SL_T0,   SL_G,    7'd0);
            7'd46: r = mk(OP_ADD,  SL_T0,   SL_T0,   SL_V,    7'd0);
            7'd47: r = mk(OP_MUL,  SL_H2,   SL_FMD,  SL_T0,   7'd0);
            7'd48: r = mk(OP_DIV,  SL_T0,   SL_NZ,   SL_DN,   7'd0);
            7'd49: r = mk(OP_MUL,  SL_T0,   SL_T0,   SL_K,    7'd0);
            7'd50: r = mk(OP_DIV,  SL_T0,   SL_T0,   SL_G,    7'd0);
            7'd51: r = mk(OP_ADD,  SL_T0,   SL_T0,   SL_W,    7'd0);
            7'd52: r = mk(OP_MUL,  SL_H3,   SL_FMD,  SL_T0,   7'd0);
            7'd53: r = mk(OP_MUL,  SL_T0,   SL_VDN,  SL_K,    7'd0);
            7'd54: r = mk(OP_ADD,  SL_T1,   SL_G,    SL_ONE,  7'd0);
            7'd55: r = mk(OP_DIV,  SL_EN,   SL_T0,   SL_T1,   7'd0);
            7'd56: r = mk(OP_MUL,  SL_T0,   SL_TWOC, SL_C,    7'd0);
            7'd57: r = mk(OP_MUL,  SL_T1,   SL_G,    SL_G,    7'd0);
            7'd58: r = mk(OP_SUB,  SL_T1,   SL_T1,   SL_ONE,  7'd0);
            7'd59: r = mk(OP_DIV,  SL_T0,   SL_T0,   SL_T1,   7'd0);
            7'd60: r = mk(OP_ADD,  SL_EN,   SL_EN,   SL_T0,   7'd0);
            7'd61: r = mk(OP_MUL,  SL_T0,   SL_HALF, SL_V2,   7'd0);
            7'd62: r = mk(OP_ADD,  SL_EN,   SL_EN,   SL_T0,   7'd0);
            7'd63: r = mk(OP_MUL,  SL_T0,   SL_NT,   SL_K,    7'd0);
            7'd64: r = mk(OP_DIV,  SL_T0,   SL_T0,   SL_G,    7'd0);
            7'd65: r = mk(OP_SUB,  SL_EN,   SL_EN,   SL_T0,   7'd0);
            7'd66: r = mk(OP_MUL,  SL_H4,   SL_FMD,  SL_EN,   7'd0);
            7'd67: r = mk(OP_JMP,  SL_T0,   SL_T0,   SL_T0,   L_FIN);
            // full flux
            7'd68: r = mk(OP_MUL,  SL_FM,   SL_RHO,  SL_VN,   7'd0);
            7'd69: r = mk(OP_MUL,  SL_T0,   SL_FM,   SL_U,    7'd0);
            7'd70: r = mk(OP_MUL,  SL_T1,   SL_P,    SL_NX,   7'd0);
            7'd71: r = mk(OP_ADD,  SL_H1,   SL_T0,   SL_T1,   7'd0);
            7'd72: r = mk(OP_MUL,  SL_T0,   SL_FM,   SL_V,    7'd0);
            7'd73: r = mk(OP_MUL,  SL_T1,   SL_P,    SL_NY,   7'd0);
            7'd74: r = mk(OP_ADD,  SL_H2,   SL_T0,   SL_T1,   7'd0);
            7'd75: r = mk(OP_MUL,  SL_T0,   SL_FM,   SL_W,    7'd0);
            7'd76: r = mk(OP_MUL,  SL_T1,   SL_P,    SL_NZ,   7'd0);
            7'd77: r = mk(OP_ADD,  SL_H3,   SL_T0,   SL_T1,   7'd0);
            7'd78: r = mk(OP_MUL,  SL_T0,   SL_RHO,  SL_E,    7'd0);
            7'd79: r = mk(OP_ADD,  SL_T0,   SL_T0,   SL_P,    7'd0);
            7'd80: r = mk(OP_MUL,  SL_T0,   SL_VN,   SL_T0,   7'd0);
            7'd81: r = mk(OP_MUL,  SL_T1,   SL_P,    SL_NT,   7'd0);
            7'd82: r = mk(OP_SUB,  SL_H4,   SL_T0,   SL_T1,   7'd0);
            7'd83: r = mk(OP_ADD,  SL_FMD,  SL_FM,   SL_ZERO, 7'd0);
            // hand the half flux over
            7'd84: r = mk(OP_FIN,  FX_MASS, SL_FMD,  SL_FMD,  7'd0);
            7'd85: r = mk(OP_FIN,  FX_MX,   SL_H1,   SL_H1,   7'd0);
            7'd86: r = mk(OP_FIN,  FX_MY,   SL_H2,   SL_H2,   7'd0);
            7'd87: r = mk(OP_FIN,  FX_MZ,   SL_H3,   SL_H3,   7'd0);
            7'd88: r = mk(OP_FIN,  FX_EN,   SL_H4,   SL_H4,   7'd0);
            7'd89: r = mk(OP_END,  SL_T0,   SL_T0,   SL_T0,   7'd0);
            // no flux
            7'd90: r = mk(OP_FIN,  FX_MASS, SL_ZERO, SL_ZERO, 7'd0);
            7'd91: r = mk(OP_FIN,  FX_MX,   SL_ZERO, SL_ZERO, 7'd0);
            7'd92: r = mk(OP_FIN,  FX_MY,   SL_ZERO, SL_ZERO, 7'd0);
            7'd93: r = mk(OP_FIN,  FX_MZ,   SL_ZERO, SL_ZERO, 7'd0);
            7'd94: r = mk(OP_FIN,  FX_EN,   SL_ZERO, SL_ZERO, 7'd0);
            default: r = mk(OP_END, SL_T0,  SL_T0,   SL_T0,   7'd0);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/flux_vector_splitting_core.sv =====
// ----------------------------------------------------------------------------
// flux_vector_splitting_core: Van Leer split flux with grid motion
// Takes the left and right states of a face and emits the five flux
// components, Q15.16 fixed point with saturation.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  s_axis    in         i_s_axis_tvalid/o_..tready  tdata: state, tuser: side
//  m_axis    out        o_m_axis_tvalid/i_..tready  tdata: five flux values
//  cfg       in         i_cfg_wr_en                 i_cfg_addr, i_cfg_wr_data
//
// One item at a time: intake loads fifteen slots, then a microprogram runs
// on one shared 32x32 multiplier, a radix-2 divider and a 2-bit-per-step
// root. An item runs longest on the polynomial branch, shorter on the
// full-flux branch and shortest when no flux passes; a zero divisor or
// root argument shortens it, and the divider sets most of the run time.
// Reset (synchronous, active low) clears the held half flux, the gammas
// to 1.4 and the output valid. A finished result waits in the output
// register while the next item is taken; the next right item stalls at
// handoff until that register is read.
//
`default_nettype none

module flux_vector_splitting_core #(
    parameter int DATA_WIDTH = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // density, vel_x, vel_y, vel_z, pressure, normal_x, normal_y, normal_z,
    // grid_speed_term; two zero pad bits on top
    input  wire [287:0]  i_s_axis_tdata,
    // side
    input  wire          i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // flux_mass, flux_mom_x, flux_mom_y, flux_mom_z, flux_energy
    output logic [159:0] o_m_axis_tdata,
    input  wire          i_cfg_wr_en,
    input  wire          i_cfg_addr,
    input  wire [17:0]   i_cfg_wr_data
);

    logic [fvs_pkg::CfgW-1:0] r_gamma_left, r_gamma_right;
    fvs_pkg::t_item           item;
    fvs_pkg::t_cmd            cmd;
    fvs_pkg::t_stat           stat;

    // gamma registers; to be written only while idle (binds the user; the block does not enforce it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma_left  <= fvs_pkg::GAMMA_RESET;
            r_gamma_right <= fvs_pkg::GAMMA_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_addr == fvs_pkg::CFG_GAMMA_LEFT) begin
                r_gamma_left <= i_cfg_wr_data;
            end else begin
                r_gamma_right <= i_cfg_wr_data;
            end
        end
    end

    // unpack the input item
    always_comb begin
        item.side            = i_s_axis_tuser;
        item.density         = i_s_axis_tdata[30:0];
        item.vel_x           = $signed(i_s_axis_tdata[62:31]);
        item.vel_y           = $signed(i_s_axis_tdata[94:63]);
        item.vel_z           = $signed(i_s_axis_tdata[126:95]);
        item.pressure        = i_s_axis_tdata[157:127];
        item.normal_x        = $signed(i_s_axis_tdata[189:158]);
        item.normal_y        = $signed(i_s_axis_tdata[221:190]);
        item.normal_z        = $signed(i_s_axis_tdata[253:222]);
        item.grid_speed_term = $signed(i_s_axis_tdata[285:254]);
    end

    fvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fvs_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_item        (item),
        .i_gamma_left  (r_gamma_left),
        .i_gamma_right (r_gamma_right),
        .o_stat        (stat),
        .o_result      (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/fvs_dp.sv =====
// ----------------------------------------------------------------------------
// fvs_dp: flux datapath
// Scratch memory, shared multiplier, iterative divider and square root,
// held half flux and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fvs_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  fvs_pkg::t_cmd               i_cmd,
    input  fvs_pkg::t_item              i_item,
    input  wire [fvs_pkg::CfgW-1:0]     i_gamma_left,
    input  wire [fvs_pkg::CfgW-1:0]     i_gamma_right,
    output fvs_pkg::t_stat              o_stat,
    output logic [32*fvs_pkg::NumFlux-1:0] o_result
);

    localparam int WEFF = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
    localparam logic signed [65:0] QMAX = (66'sd1 <<< (WEFF - 1)) - 66'sd1;
    localparam logic signed [65:0] QMIN = -QMAX - 66'sd1;

    function automatic logic signed [31:0] f_sat(input logic signed [65:0] x);
        if (x > QMAX) begin
            return QMAX[31:0];
        end else if (x < QMIN) begin
            return QMIN[31:0];
        end
        return x[31:0];
    endfunction

    function automatic logic [31:0] f_mag(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic signed [31:0] f_sgn(input logic [48:0] m, input logic neg);
        logic signed [65:0] v;
        v = $signed({17'b0, m});
        return f_sat(neg ? -v : v);
    endfunction

    // scratch memory
    logic signed [31:0] r_mem [64];
    logic signed [31:0] r_rd_a, r_rd_b;
    logic               wr_en;
    logic [fvs_pkg::SlotW-1:0] wr_addr;
    logic signed [31:0] wr_data;

    fvs_pkg::t_item     r_item;
    fvs_pkg::t_op       r_op;
    logic [fvs_pkg::SlotW-1:0] r_dst;

    logic               r_mul_pend;
    logic [63:0]        r_prod;
    logic [63:0]        r_acc;

    logic               r_div_run;
    logic               r_neg;
    logic [31:0]        r_rem;
    logic [47:0]        r_num;
    logic [31:0]        r_den;
    logic [47:0]        r_quo;

    logic               r_sqrt_run;
    logic [63:0]        r_rad;
    logic [35:0]        r_srem;
    logic [32:0]        r_root;

    logic [5:0]         r_cnt;

    logic signed [31:0] r_held [fvs_pkg::NumFlux];
    logic signed [31:0] r_res  [fvs_pkg::NumFlux];
    logic signed [31:0] r_out  [fvs_pkg::NumFlux];

    fvs_pkg::t_op       op;
    logic               go_simple, div_zero, sqrt_zero, div_fin, sqrt_fin;
    logic               ge_one, le_mone;
    logic signed [65:0] ea, eb;
    logic signed [31:0] alu;
    logic signed [31:0] intake_val;
    logic [32:0]        div_trial;
    logic [35:0]        sq_rem;
    logic [35:0]        sq_trial;
    logic [2:0]         fx;

    assign op = i_cmd.ins.op;
    assign ea = 66'(r_rd_a);
    assign eb = 66'(r_rd_b);
    assign fx = i_cmd.ins.dst[2:0];

    assign ge_one  = (r_rd_a >= fvs_pkg::Q_ONE);
    assign le_mone = (r_rd_a <= -fvs_pkg::Q_ONE);

    assign go_simple = i_cmd.go && (op == fvs_pkg::OP_ADD || op == fvs_pkg::OP_SUB ||
                       op == fvs_pkg::OP_ADDS || op == fvs_pkg::OP_NEGR ||
                       op == fvs_pkg::OP_BRNONE || op == fvs_pkg::OP_BRFULL ||
                       op == fvs_pkg::OP_FIN);
    assign div_zero  = i_cmd.go && op == fvs_pkg::OP_DIV && r_rd_b == 32'sd0;
    assign sqrt_zero = i_cmd.go && op == fvs_pkg::OP_SQRT && r_rd_a <= 32'sd0;
    assign div_fin   = r_div_run && r_cnt == 6'd0;
    assign sqrt_fin  = r_sqrt_run && r_cnt == 6'd0;

    always_comb begin
        o_stat.done = go_simple || div_zero || sqrt_zero || r_mul_pend || div_fin || sqrt_fin;
        o_stat.side = r_item.side;
        if (op == fvs_pkg::OP_BRNONE) begin
            o_stat.take = r_item.side ? ge_one : le_mone;
        end else begin
            o_stat.take = r_item.side ? le_mone : ge_one;
        end
    end

    always_comb begin
        case (op)
            fvs_pkg::OP_ADD:  alu = f_sat(ea + eb);
            fvs_pkg::OP_SUB:  alu = f_sat(ea - eb);
            fvs_pkg::OP_ADDS: alu = r_item.side ? f_sat(ea - eb) : f_sat(ea + eb);
            fvs_pkg::OP_NEGR: alu = r_item.side ? f_sat(-ea) : r_rd_a;
            default:          alu = r_rd_a;
        endcase
    end

    // intake loads the item, gamma and the constants into fixed slots
    always_comb begin
        case (i_cmd.idx)
            fvs_pkg::SL_RHO[3:0]:  intake_val = f_sat(66'($signed({1'b0, r_item.density})));
            fvs_pkg::SL_U[3:0]:    intake_val = f_sat(66'(r_item.vel_x));
            fvs_pkg::SL_V[3:0]:    intake_val = f_sat(66'(r_item.vel_y));
            fvs_pkg::SL_W[3:0]:    intake_val = f_sat(66'(r_item.vel_z));
            fvs_pkg::SL_P[3:0]:    intake_val = f_sat(66'($signed({1'b0, r_item.pressure})));
            fvs_pkg::SL_NX[3:0]:   intake_val = f_sat(66'(r_item.normal_x));
            fvs_pkg::SL_NY[3:0]:   intake_val = f_sat(66'(r_item.normal_y));
            fvs_pkg::SL_NZ[3:0]:   intake_val = f_sat(66'(r_item.normal_z));
            fvs_pkg::SL_NT[3:0]:   intake_val = f_sat(66'(r_item.grid_speed_term));
            fvs_pkg::SL_G[3:0]:    intake_val = f_sat(66'($signed({1'b0,
                                       r_item.side ? i_gamma_right : i_gamma_left})));
            fvs_pkg::SL_HALF[3:0]: intake_val = fvs_pkg::Q_HALF;
            fvs_pkg::SL_QTR[3:0]:  intake_val = fvs_pkg::Q_QUARTER;
            fvs_pkg::SL_ONE[3:0]:  intake_val = fvs_pkg::Q_ONE;
            fvs_pkg::SL_TWO[3:0]:  intake_val = fvs_pkg::Q_TWO;
            default:               intake_val = fvs_pkg::Q_ZERO;
        endcase
    end

    assign div_trial = {r_rem, r_num[47]};
    assign sq_rem    = {r_srem[33:0], r_rad[63:62]};
    assign sq_trial  = {1'b0, r_root, 2'b01};

    // write port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_dst;
        wr_data = fvs_pkg::Q_ZERO;
        if (i_cmd.intake) begin
            wr_en   = 1'b1;
            wr_addr = {2'b00, i_cmd.idx};
            wr_data = intake_val;
        end else if (go_simple && op != fvs_pkg::OP_BRNONE && op != fvs_pkg::OP_BRFULL &&
                     op != fvs_pkg::OP_FIN) begin
            wr_en   = 1'b1;
            wr_addr = i_cmd.ins.dst;
            wr_data = alu;
        end else if (div_zero) begin
            wr_en   = 1'b1;
            wr_addr = i_cmd.ins.dst;
            wr_data = (r_rd_a > 32'sd0) ? QMAX[31:0] :
                      ((r_rd_a < 32'sd0) ? QMIN[31:0] : fvs_pkg::Q_ZERO);
        end else if (sqrt_zero) begin
            wr_en   = 1'b1;
            wr_addr = i_cmd.ins.dst;
        end else if (r_mul_pend && r_op == fvs_pkg::OP_MUL) begin
            wr_en   = 1'b1;
            wr_data = f_sgn(49'((r_prod + 64'd32768) >> 16), r_neg);
        end else if (div_fin) begin
            wr_en   = 1'b1;
            wr_data = f_sgn(49'(r_quo) + 49'({r_rem, 1'b0} >= {1'b0, r_den}), r_neg);
        end else if (sqrt_fin) begin
            wr_en   = 1'b1;
            wr_data = f_sgn({16'b0, r_root}, 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_mem[i_cmd.ins.a];
            r_rd_b <= r_mem[i_cmd.ins.b];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.go) begin
            r_op   <= op;
            r_dst  <= i_cmd.ins.dst;
            r_prod <= f_mag(r_rd_a) * f_mag(r_rd_b);
            r_neg  <= r_rd_a[31] ^ r_rd_b[31];
            r_rem  <= '0;
            r_num  <= {f_mag(r_rd_a), 16'b0};
            r_den  <= f_mag(r_rd_b);
            r_quo  <= '0;
            r_rad  <= (op == fvs_pkg::OP_NORM) ? r_acc : {16'b0, r_rd_a, 16'b0};
            r_srem <= '0;
            r_root <= '0;
            r_cnt  <= (op == fvs_pkg::OP_DIV) ? 6'd48 : 6'd32;
        end else begin
            if (r_mul_pend) begin
                if (r_op == fvs_pkg::OP_SQ0) begin
                    r_acc <= r_prod;
                end else if (r_op == fvs_pkg::OP_SQA) begin
                    r_acc <= r_acc + r_prod;
                end
            end
            if (r_div_run && r_cnt != 6'd0) begin
                r_num <= {r_num[46:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (div_trial >= {1'b0, r_den}) begin
                    r_rem <= 32'(div_trial - {1'b0, r_den});
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= div_trial[31:0];
                    r_quo <= {r_quo[46:0], 1'b0};
                end
            end
            if (r_sqrt_run && r_cnt != 6'd0) begin
                r_rad <= {r_rad[61:0], 2'b00};
                r_cnt <= r_cnt - 6'd1;
                if (sq_rem >= sq_trial) begin
                    r_srem <= sq_rem - sq_trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_srem <= sq_rem;
                    r_root <= {r_root[31:0], 1'b0};
                end
            end
        end
        if (go_simple && op == fvs_pkg::OP_FIN && r_item.side) begin
            r_res[fx] <= f_sat(66'(r_held[fx]) + ea);
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    // control state of the units and the held half flux
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_pend <= 1'b0;
            r_div_run  <= 1'b0;
            r_sqrt_run <= 1'b0;
            for (int i = 0; i < fvs_pkg::NumFlux; i++) begin
                r_held[i] <= fvs_pkg::Q_ZERO;
            end
        end else begin
            r_mul_pend <= i_cmd.go && (op == fvs_pkg::OP_MUL || op == fvs_pkg::OP_SQ0 ||
                          op == fvs_pkg::OP_SQA);
            if (i_cmd.go && op == fvs_pkg::OP_DIV && !div_zero) begin
                r_div_run <= 1'b1;
            end else if (div_fin) begin
                r_div_run <= 1'b0;
            end
            if (i_cmd.go && (op == fvs_pkg::OP_NORM ||
                             (op == fvs_pkg::OP_SQRT && !sqrt_zero))) begin
                r_sqrt_run <= 1'b1;
            end else if (sqrt_fin) begin
                r_sqrt_run <= 1'b0;
            end
            if (go_simple && op == fvs_pkg::OP_FIN) begin
                r_held[fx] <= r_item.side ? fvs_pkg::Q_ZERO : r_rd_a;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < fvs_pkg::NumFlux; i++) begin
            o_result[32*i +: 32] = r_out[i];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fvs_ctrl: flux controller
// Sequences intake, the microprogram and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module fvs_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    input  fvs_pkg::t_stat i_stat,
    output fvs_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_INTAKE = 6'b000010,
        S_READ   = 6'b000100,
        S_EXEC   = 6'b001000,
        S_WAIT   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [fvs_pkg::PcW-1:0]     r_pc, n_pc;
    logic [fvs_pkg::IdxW-1:0]    r_idx, n_idx;
    logic                        r_out_valid, n_out_valid;
    fvs_pkg::t_instr             ins;

    assign ins         = fvs_pkg::ucode(r_pc);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd          = '0;
        o_cmd.ins      = ins;
        o_cmd.idx      = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_idx   = '0;
                    n_state = S_INTAKE;
                end
            end
            S_INTAKE: begin
                o_cmd.intake = 1'b1;
                n_idx = r_idx + 4'd1;
                if (r_idx == fvs_pkg::INTAKE_LAST) begin
                    n_pc    = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                case (ins.op)
                    fvs_pkg::OP_JMP: n_pc = ins.tgt;
                    fvs_pkg::OP_END: n_state = i_stat.side ? S_EMIT : S_IDLE;
                    default: begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_EXEC;
                    end
                endcase
            end
            S_EXEC: begin
                o_cmd.go = 1'b1;
                if (i_stat.done) begin
                    n_state = S_READ;
                    if ((ins.op == fvs_pkg::OP_BRNONE || ins.op == fvs_pkg::OP_BRFULL) &&
                        i_stat.take) begin
                        n_pc = ins.tgt;
                    end else begin
                        n_pc = r_pc + 7'd1;
                    end
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_stat.done) begin
                    n_pc    = r_pc + 7'd1;
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
